// ----- rtl/nird_pkg.sv -----
// Shared types and constants for the NEC infrared frame decoder.
// No dependencies; the channel interfaces and all RTL modules use it.
`default_nettype none

package nird_pkg;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_DELAY     = 3'd1,
      PH_LEAD_LOW  = 3'd2,
      PH_LEAD_HIGH = 3'd3,
      PH_BIT_LOW   = 3'd4,
      PH_BIT_HIGH  = 3'd5
   } phase_type;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_ADDR_FAIL = 3'd1;
   localparam logic [2:0] ST_CMD_FAIL  = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_LEADER    = 3'd4;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] REG_START_DELAY         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LEADER_LOW_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LEADER_HIGH_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_LOW_TIMEOUT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_HIGH_TIMEOUT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_HIGH_TICKS      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_THRESHOLD       = 3'd6;

   // Configuration reset values
   localparam logic [9:0]  RST_START_DELAY         = 10'd50;
   localparam logic [11:0] RST_LEADER_LOW_TIMEOUT  = 12'd1000;
   localparam logic [11:0] RST_LEADER_HIGH_TIMEOUT = 12'd500;
   localparam logic [11:0] RST_BIT_LOW_TIMEOUT     = 12'd60;
   localparam logic [11:0] RST_BIT_HIGH_TIMEOUT    = 12'd500;
   localparam logic [7:0]  RST_MAX_HIGH_TICKS      = 8'd25;
   localparam logic [7:0]  RST_ONE_THRESHOLD       = 8'd10;

   typedef struct packed {
      logic [9:0]  start_delay;
      logic [11:0] leader_low_timeout;
      logic [11:0] leader_high_timeout;
      logic [11:0] bit_low_timeout;
      logic [11:0] bit_high_timeout;
      logic [7:0]  max_high_ticks;
      logic [7:0]  one_threshold;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [11:0] wait_counter;
      logic [8:0]  high_length;
      logic [4:0]  bit_index;
      logic [31:0] frame_bits;
   } state_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] address;
      logic [7:0] command;
      logic [2:0] status;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/nird_if.sv -----
// Valid/ready channel interfaces of the NEC infrared frame decoder.
// Depends on nird_pkg for the configuration port widths.
`default_nettype none

interface nird_req_if;
   logic valid;
   logic ready;
   logic ir_level;

   modport source (output valid, output ir_level, input ready);
   modport sink   (input valid, input ir_level, output ready);
endinterface

interface nird_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] address;
   logic [7:0] command;
   logic [2:0] status;

   modport source (output valid, output address, output command, output status, input ready);
   modport sink   (input valid, input address, input command, input status, output ready);
endinterface

interface nird_csr_if;
   logic                             valid;
   logic                             ready;
   logic [nird_pkg::CSR_INDEX_W-1:0] index;
   logic [nird_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/nird_step.sv -----
// One-sample step of the NEC decoder: next state and result from the current state.
// Depends on nird_pkg (state, config and result types, phase and status codes).
`default_nettype none

module nird_step (
   input  nird_pkg::state_type  state_cur,
   input  nird_pkg::cfg_type    cfg,
   input  logic                 level,
   output nird_pkg::state_type  state_nxt,
   output nird_pkg::result_type result
);

   // Shift count bits of value v into byte k from the top; optionally
   // set every later byte to all v.
   function automatic logic [31:0] shift_bits(input logic [31:0] fb, input logic [1:0] k,
                                              input logic [3:0] count, input logic v,
                                              input logic fill_rest);
      logic [31:0] r;
      logic [15:0] t;
      r = fb;
      for (int j = 0; j < 4; j++) begin
         t = {{8{v}}, fb[8*j +: 8]} >> count;
         if (j == int'(k)) begin
            r[8*j +: 8] = t[7:0];
         end else if (fill_rest && (j > int'(k))) begin
            r[8*j +: 8] = {8{v}};
         end
      end
      return r;
   endfunction

   nird_pkg::state_type s;
   logic                done;
   logic                emit;
   logic [2:0]          code;
   logic                bit_val;
   logic [7:0]          a0, a1, c0, c1;

   // Next state: phases are walked in order, as many as the sample lets
   // finish in this step. A second bit pass covers zero timeouts, where all
   // remaining bits are taken in the same tick with zero space length.
   always_comb begin
      s       = state_cur;
      done    = 1'b0;
      emit    = 1'b0;
      code    = nird_pkg::ST_OK;
      bit_val = 1'b0;

      // idle, and any unused phase code
      if (!(s.phase inside {nird_pkg::PH_DELAY, nird_pkg::PH_LEAD_LOW, nird_pkg::PH_LEAD_HIGH,
                            nird_pkg::PH_BIT_LOW, nird_pkg::PH_BIT_HIGH})) begin
         if (!level) begin
            s.wait_counter = '0;
            s.phase        = nird_pkg::PH_DELAY;
         end else begin
            s.phase = nird_pkg::PH_IDLE;
            done    = 1'b1;
         end
      end

      // start confirmation delay
      if (!done && (s.phase == nird_pkg::PH_DELAY)) begin
         if (s.wait_counter < {2'b00, cfg.start_delay}) begin
            s.wait_counter = s.wait_counter + 12'd1;
            done           = 1'b1;
         end else if (level) begin
            s.phase = nird_pkg::PH_IDLE;
            done    = 1'b1;
         end else begin
            s.wait_counter = cfg.leader_low_timeout;
            s.phase        = nird_pkg::PH_LEAD_LOW;
         end
      end

      // leader low
      if (!done && (s.phase == nird_pkg::PH_LEAD_LOW)) begin
         if (!level && (s.wait_counter != '0)) begin
            s.wait_counter = s.wait_counter - 12'd1;
            done           = 1'b1;
         end else if (!level) begin
            emit    = 1'b1;
            code    = nird_pkg::ST_LEADER;
            s.phase = nird_pkg::PH_IDLE;
            done    = 1'b1;
         end else begin
            s.wait_counter = cfg.leader_high_timeout;
            s.phase        = nird_pkg::PH_LEAD_HIGH;
         end
      end

      // leader high
      if (!done && (s.phase == nird_pkg::PH_LEAD_HIGH)) begin
         if (level && (s.wait_counter != '0)) begin
            s.wait_counter = s.wait_counter - 12'd1;
            done           = 1'b1;
         end else begin
            s.bit_index    = '0;
            s.wait_counter = cfg.bit_low_timeout;
            s.phase        = nird_pkg::PH_BIT_LOW;
         end
      end

      // bit low mark, first pass
      if (!done && (s.phase == nird_pkg::PH_BIT_LOW)) begin
         if (!level && (s.wait_counter != '0)) begin
            s.wait_counter = s.wait_counter - 12'd1;
            done           = 1'b1;
         end else begin
            s.high_length  = '0;
            s.wait_counter = cfg.bit_high_timeout;
            s.phase        = nird_pkg::PH_BIT_HIGH;
         end
      end

      // bit high space, first pass
      if (!done && (s.phase == nird_pkg::PH_BIT_HIGH)) begin
         if (level && (s.wait_counter != '0)) begin
            s.wait_counter = s.wait_counter - 12'd1;
            s.high_length  = s.high_length + 9'd1;
            if (s.high_length > {1'b0, cfg.max_high_ticks}) begin
               emit    = 1'b1;
               code    = nird_pkg::ST_TOO_LONG;
               s.phase = nird_pkg::PH_IDLE;
            end
            done = 1'b1;
         end else begin
            bit_val      = (s.high_length >= {1'b0, cfg.one_threshold});
            s.frame_bits = shift_bits(s.frame_bits, s.bit_index[4:3], 4'd1, bit_val, 1'b0);
            s.high_length = '0;
            if (s.bit_index == 5'd31) begin
               s.bit_index = '0;
               emit        = 1'b1;
               s.phase     = nird_pkg::PH_IDLE;
               done        = 1'b1;
            end else begin
               s.bit_index    = s.bit_index + 5'd1;
               s.wait_counter = cfg.bit_low_timeout;
               s.phase        = nird_pkg::PH_BIT_LOW;
            end
         end
      end

      // bit low mark, second pass
      if (!done && (s.phase == nird_pkg::PH_BIT_LOW)) begin
         if (!level && (s.wait_counter != '0)) begin
            s.wait_counter = s.wait_counter - 12'd1;
            done           = 1'b1;
         end else begin
            s.high_length  = '0;
            s.wait_counter = cfg.bit_high_timeout;
            s.phase        = nird_pkg::PH_BIT_HIGH;
         end
      end

      // bit high space, second pass: the loop either stops here or
      // takes every remaining bit with the same value
      if (!done && (s.phase == nird_pkg::PH_BIT_HIGH)) begin
         if (level && (s.wait_counter != '0)) begin
            s.wait_counter = s.wait_counter - 12'd1;
            s.high_length  = s.high_length + 9'd1;
            if (s.high_length > {1'b0, cfg.max_high_ticks}) begin
               emit    = 1'b1;
               code    = nird_pkg::ST_TOO_LONG;
               s.phase = nird_pkg::PH_IDLE;
            end
            done = 1'b1;
         end else begin
            bit_val      = (cfg.one_threshold == 8'd0);
            s.frame_bits = shift_bits(s.frame_bits, s.bit_index[4:3],
                                      4'd8 - {1'b0, s.bit_index[2:0]}, bit_val, 1'b1);
            s.high_length = '0;
            s.bit_index   = '0;
            emit          = 1'b1;
            s.phase       = nird_pkg::PH_IDLE;
            done          = 1'b1;
         end
      end

      state_nxt = s;
   end

   // Result fields: complement checks on a finished frame, zeros on an abort
   always_comb begin
      a0 = state_nxt.frame_bits[7:0];
      a1 = state_nxt.frame_bits[15:8];
      c0 = state_nxt.frame_bits[23:16];
      c1 = state_nxt.frame_bits[31:24];
      result.emit = emit;
      if (code == nird_pkg::ST_OK) begin
         result.address = a0;
         result.command = c0;
         if (a0 != ~a1) begin
            result.status = nird_pkg::ST_ADDR_FAIL;
         end else if (c0 != ~c1) begin
            result.status = nird_pkg::ST_CMD_FAIL;
         end else begin
            result.status = nird_pkg::ST_OK;
         end
      end else begin
         result.address = '0;
         result.command = '0;
         result.status  = code;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/nec_ir_frame_decoder.sv -----
// Top level of the NEC infrared frame decoder: channels, registers, pipeline control.
// Depends on nird_pkg, the nird_*_if channel interfaces and nird_step.
//
// Takes one receiver line sample per transfer on req_bus and returns a frame
// result (address, command, status) on rsp_bus when a frame completes or aborts.
// Each sample is held in an input register, stepped through the decoder state
// when the output slot frees, and any result lands in the output register.
// A sample can be taken every cycle while no result waits; a result that waits on
// rsp_bus holds the decoder state, and the input register then holds one more
// sample before req_bus.ready drops. Configuration writes on csr_bus are
// registered and must be made while the decoder is idle.
`default_nettype none

module nec_ir_frame_decoder (
   input  logic              clock,
   input  logic              reset,
   nird_req_if.sink          req_bus,
   nird_rsp_if.source        rsp_bus,
   nird_csr_if.sink          csr_bus
);

   nird_pkg::cfg_type    cfg_ff, cfg_in;
   nird_pkg::state_type  state_ff, state_in;
   nird_pkg::state_type  state_nxt;
   nird_pkg::result_type step_res;
   nird_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 in_level_ff, in_level_in;
   logic                 advance;
   logic                 req_take;

   // Configuration registers, always ready
   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            nird_pkg::REG_START_DELAY:         cfg_in.start_delay = csr_bus.data[9:0];
            nird_pkg::REG_LEADER_LOW_TIMEOUT:  cfg_in.leader_low_timeout = csr_bus.data;
            nird_pkg::REG_LEADER_HIGH_TIMEOUT: cfg_in.leader_high_timeout = csr_bus.data;
            nird_pkg::REG_BIT_LOW_TIMEOUT:     cfg_in.bit_low_timeout = csr_bus.data;
            nird_pkg::REG_BIT_HIGH_TIMEOUT:    cfg_in.bit_high_timeout = csr_bus.data;
            nird_pkg::REG_MAX_HIGH_TICKS:      cfg_in.max_high_ticks = csr_bus.data[7:0];
            nird_pkg::REG_ONE_THRESHOLD:       cfg_in.one_threshold = csr_bus.data[7:0];
            default:                           cfg_in = cfg_ff;
         endcase
      end
   end

   // Handshake control: step when a sample is held and the output slot frees
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   // Decoder step
   nird_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .level     (in_level_ff),
      .state_nxt (state_nxt),
      .result    (step_res)
   );

   // Next values of the pipeline registers
   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      in_level_in  = req_take ? req_bus.ir_level : in_level_ff;
      state_in     = advance ? state_nxt : state_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_bus.ready) || (advance && step_res.emit);
      rsp_data_in  = (advance && step_res.emit) ? step_res : rsp_data_ff;
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay         <= nird_pkg::RST_START_DELAY;
         cfg_ff.leader_low_timeout  <= nird_pkg::RST_LEADER_LOW_TIMEOUT;
         cfg_ff.leader_high_timeout <= nird_pkg::RST_LEADER_HIGH_TIMEOUT;
         cfg_ff.bit_low_timeout     <= nird_pkg::RST_BIT_LOW_TIMEOUT;
         cfg_ff.bit_high_timeout    <= nird_pkg::RST_BIT_HIGH_TIMEOUT;
         cfg_ff.max_high_ticks      <= nird_pkg::RST_MAX_HIGH_TICKS;
         cfg_ff.one_threshold       <= nird_pkg::RST_ONE_THRESHOLD;
         state_ff.phase             <= nird_pkg::PH_IDLE;
         state_ff.wait_counter      <= '0;
         state_ff.high_length       <= '0;
         state_ff.bit_index         <= '0;
         state_ff.frame_bits        <= '0;
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_level_ff <= in_level_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Result channel
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.address = rsp_data_ff.address;
   assign rsp_bus.command = rsp_data_ff.command;
   assign rsp_bus.status  = rsp_data_ff.status;

   // Checks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.status <= nird_pkg::ST_LEADER))
      else $error("result status code out of range");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_data_ff.status == nird_pkg::ST_TOO_LONG) ||
                        (rsp_data_ff.status == nird_pkg::ST_LEADER)))
      |-> ((rsp_data_ff.address == 8'd0) && (rsp_data_ff.command == 8'd0)))
      else $error("aborted frame carries nonzero address or command");

   assert property (@(posedge clock) disable iff (reset)
      (advance && step_res.emit) |=> (state_ff.phase == nird_pkg::PH_IDLE))
      else $error("decoder not idle after giving a result");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_level_ff)))
      else $error("held sample lost or changed while stalled");

endmodule

`default_nettype wire
